@@ rtl/sgs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the sigmoid table builder for the sigmoid gradient scaler.
// No dependencies.
package sgs_pkg;

    localparam int CLAMP_LIMIT      = 6;
    localparam int DEF_TABLE_DEPTH  = 1024;
    localparam int MAX_ELEMENTS     = 1048576;
    localparam int Q12_ONE          = 4096;
    localparam int Q16_ONE          = 65536;
    localparam int TAYLOR_TERMS     = 24;
    localparam int SCORE_LIMIT      = CLAMP_LIMIT * Q12_ONE;

    // index = floor(floor(pos * depth / 8192) / CLAMP_LIMIT), reciprocal is exact here
    localparam int IDX_SHIFT        = 13;
    localparam int RECIP_SHIFT      = 20;
    localparam int RECIP_W          = 21;
    localparam int RECIP            = ((1 << RECIP_SHIFT) + CLAMP_LIMIT - 1) / CLAMP_LIMIT;

    localparam int SIG_W            = 17;
    localparam int DIFF_W           = 18;
    localparam int PROD_W           = 35;
    localparam int GRAD_W           = 17;
    localparam int CFG_W            = 16;
    localparam int ROW_WIDTH_RST    = 1;
    localparam int LEARN_RATE_RST   = 1638;

    typedef enum logic {
        REG_ROW_WIDTH     = 1'b0,
        REG_LEARNING_RATE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic sat_hi;
        logic sat_lo;
        logic label;
        logic last;
    } sgs_ctrl_t;

    function automatic logic [63:0] ek_const(input logic [2:0] k);
        logic [63:0] v;
        unique case (k)
            3'd0:    v = 64'd4294967296;
            3'd1:    v = 64'd1580030169;
            3'd2:    v = 64'd581260615;
            3'd3:    v = 64'd213833831;
            3'd4:    v = 64'd78665071;
            3'd5:    v = 64'd28939262;
            3'd6:    v = 64'd10646160;
            default: v = 64'd3916504;
        endcase
        return v;
    endfunction

    // restoring long division, only evaluated while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], a[i]};
            if (rem >= b)
            begin
                rem    = rem - b;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // t is |x| in Q32; neg selects e^-|x| / (1 + e^-|x|)
    function automatic logic [SIG_W-1:0] sig_entry(input logic neg, input logic [63:0] t);
        logic [63:0] k;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] ef;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        longint      sum;
        k    = t >> 32;
        f    = t & 64'hFFFF_FFFF;
        term = 64'h1_0000_0000;
        sum  = longint'(term);
        for (int n = 1; n <= TAYLOR_TERMS; n++)
        begin
            term = udiv64((term * f) >> 32, 64'(n));
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        ef = 64'(sum);
        if (k > 64'd7)
            k = 64'd7;
        e   = (ef * ek_const(k[2:0])) >> 32;
        num = neg ? e : 64'h1_0000_0000;
        den = 64'h1_0000_0000 + e;
        q   = udiv64((num << 16) + (den >> 1), den);
        return q[SIG_W-1:0];
    endfunction

endpackage

@@ rtl/sigmoid_gradient_scaler.sv @@
`timescale 1ns / 1ps
// Top level of the sigmoid gradient scaler: config registers, front and back stages, table.
// Depends on sgs_pkg, sgs_front, sgs_back, sgs_rom.
//
// Usage:
//   Input items (score, element_index, last_in) are taken at a rising edge with start
//   high and busy low. One item can be taken every cycle.
//   Each item yields one result (gradient, last_out), shown for one cycle with strobe
//   high, in input order. The receiver cannot stall, so results never back up and input
//   is never held off by the output side.
//   Throughput is one item per cycle; the pipeline is five registered stages: range and
//   index scaling, reciprocal multiply and table read, sigmoid select and difference,
//   alpha multiply, round and saturate.
//   After reset, busy stays high while the sigmoid table RAM is loaded, one entry per
//   cycle; after that busy stays low. Config (row_width at 0x0, learning_rate at 0x4) is
//   written over the APB port; the user must do so only while no item is in flight, as
//   the block does not enforce it. Reset values: row_width 1, learning_rate 1638.
module sigmoid_gradient_scaler
    import sgs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [15:0]       score,
    input  logic [19:0]              element_index,
    input  logic                     last_in,
    output logic signed [GRAD_W-1:0] gradient,
    output logic                     last_out,
    output logic                     strobe
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [CFG_W-1:0] row_width_reg;
    logic [CFG_W-1:0] learning_rate_reg;
    cfg_reg_t         cfg_sel;
    logic             cfg_wr;
    logic             accept;
    logic [AW-1:0]    tab_addr;
    logic [SIG_W-1:0] tab_data;
    sgs_ctrl_t        ctrl_s2;

    assign cfg_sel = cfg_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign accept  = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg     <= CFG_W'(ROW_WIDTH_RST);
            learning_rate_reg <= CFG_W'(LEARN_RATE_RST);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_ROW_WIDTH:     row_width_reg     <= pwdata[CFG_W-1:0];
                REG_LEARNING_RATE: learning_rate_reg <= pwdata[CFG_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_ROW_WIDTH:     prdata = 32'(row_width_reg);
            REG_LEARNING_RATE: prdata = 32'(learning_rate_reg);
            default:           prdata = '0;
        endcase
    end

    sgs_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .score         (score),
        .element_index (element_index),
        .last_in       (last_in),
        .row_width     (row_width_reg),
        .addr          (tab_addr),
        .ctrl          (ctrl_s2)
    );

    sgs_rom #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rom (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (tab_addr),
        .rdata (tab_data),
        .busy  (busy)
    );

    sgs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl_s2),
        .sig_tab       (tab_data),
        .learning_rate (learning_rate_reg),
        .gradient      (gradient),
        .last_out      (last_out),
        .strobe        (strobe)
    );

endmodule

@@ rtl/sgs_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgs_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sgs_rom.sv @@
`timescale 1ns / 1ps
// Sigmoid table: RAM loaded with the table contents by a sweep after reset.
// Depends on sgs_pkg and sgs_ram.
module sgs_rom
    import sgs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(TABLE_DEPTH)-1:0] raddr,
    output logic [SIG_W-1:0]               rdata,
    output logic                           busy
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [SIG_W-1:0] init_val [TABLE_DEPTH];
    logic             loading_reg;
    logic             loading_next;
    logic [AW-1:0]    fill_cnt_reg;
    logic [AW-1:0]    fill_cnt_next;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_init
        localparam int          SPAN = 2 * g - TABLE_DEPTH;
        localparam logic [63:0] MAG  = (SPAN < 0) ? 64'(-SPAN) : 64'(SPAN);
        localparam logic [63:0] T    = (MAG * 64'(CLAMP_LIMIT) * 64'h1_0000_0000)
                                       / 64'(TABLE_DEPTH);
        localparam logic [SIG_W-1:0] VAL = sig_entry(SPAN < 0, T);
        assign init_val[g] = VAL;
    end

    always_comb
    begin
        loading_next  = loading_reg;
        fill_cnt_next = fill_cnt_reg;
        if (loading_reg)
        begin
            fill_cnt_next = fill_cnt_reg + AW'(1);
            if (fill_cnt_reg == AW'(TABLE_DEPTH - 1))
                loading_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loading_reg  <= 1'b1;
            fill_cnt_reg <= '0;
        end
        else
        begin
            loading_reg  <= loading_next;
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    sgs_ram #(
        .WIDTH (SIG_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (loading_reg),
        .waddr (fill_cnt_reg),
        .wdata (init_val[fill_cnt_reg]),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign busy = loading_reg;

endmodule

@@ rtl/sgs_front.sv @@
`timescale 1ns / 1ps
// Front stages: range check, label, table index scaling and table address.
// Depends on sgs_pkg.
module sgs_front
    import sgs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic signed [15:0]             score,
    input  logic [19:0]                    element_index,
    input  logic                           last_in,
    input  logic [CFG_W-1:0]               row_width,
    output logic [$clog2(TABLE_DEPTH)-1:0] addr,
    output sgs_ctrl_t                      ctrl
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int QW    = $clog2(TABLE_DEPTH + 1);
    localparam int NUM_W = 16 + QW;
    localparam int X_W   = NUM_W - IDX_SHIFT;
    localparam int QF_W  = X_W + RECIP_W;

    logic signed [17:0] pos_full;
    logic [NUM_W-1:0]   num;
    logic               in_row;
    logic [QF_W-1:0]    q_full;
    logic [QW-1:0]      q;

    sgs_ctrl_t          ctrl1_next;
    sgs_ctrl_t          ctrl1_reg;
    sgs_ctrl_t          ctrl2_reg;
    logic [X_W-1:0]     x_next;
    logic [X_W-1:0]     x_reg;

    always_comb
    begin
        pos_full = 18'(score) + 18'(SCORE_LIMIT);
        num      = NUM_W'(pos_full[15:0]) * NUM_W'(TABLE_DEPTH);
        x_next   = num[NUM_W-1:IDX_SHIFT];
        in_row   = (20'(element_index) < 20'(row_width))
                   && (25'(element_index) < 25'(MAX_ELEMENTS));
        ctrl1_next.valid  = accept;
        ctrl1_next.sat_hi = 32'(signed'(score)) > SCORE_LIMIT;
        ctrl1_next.sat_lo = 32'(signed'(score)) < -SCORE_LIMIT;
        ctrl1_next.label  = !in_row;
        ctrl1_next.last   = last_in;
    end

    always_comb
    begin
        q_full = QF_W'(x_reg) * QF_W'(RECIP);
        q      = q_full[RECIP_SHIFT +: QW];
        if (q >= QW'(TABLE_DEPTH))
            addr = AW'(TABLE_DEPTH - 1);
        else
            addr = q[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end
        else
        begin
            ctrl1_reg <= ctrl1_next;
            ctrl2_reg <= ctrl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
    end

    assign ctrl = ctrl2_reg;

endmodule

@@ rtl/sgs_back.sv @@
`timescale 1ns / 1ps
// Back stages: sigmoid select, label difference, alpha multiply, round and saturate.
// Depends on sgs_pkg.
module sgs_back
    import sgs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sgs_ctrl_t                ctrl,
    input  logic [SIG_W-1:0]         sig_tab,
    input  logic [CFG_W-1:0]         learning_rate,
    output logic signed [GRAD_W-1:0] gradient,
    output logic                     last_out,
    output logic                     strobe
);

    logic [SIG_W-1:0]          sig;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W:0]    rnd;
    logic signed [PROD_W-16:0] g;
    logic [GRAD_W-1:0]         grad_next;
    logic [GRAD_W-1:0]         grad_reg;
    sgs_ctrl_t                 ctrl3_reg;
    sgs_ctrl_t                 ctrl4_reg;
    logic                      strobe_reg;
    logic                      last_reg;

    always_comb
    begin
        priority if (ctrl.sat_hi)
            sig = SIG_W'(Q16_ONE);
        else if (ctrl.sat_lo)
            sig = '0;
        else
            sig = sig_tab;
        diff_next = (ctrl.label ? DIFF_W'(Q16_ONE) : DIFF_W'(0)) - DIFF_W'(sig);
    end

    assign prod_next = PROD_W'(diff_reg) * PROD_W'(signed'({1'b0, learning_rate}));

    always_comb
    begin
        rnd = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(32768);
        g   = rnd[PROD_W:16];
        priority if (g > (PROD_W - 15)'(65535))
            grad_next = GRAD_W'(65535);
        else if (g < -(PROD_W - 15)'(65536))
            grad_next = GRAD_W'(-65536);
        else
            grad_next = g[GRAD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl3_reg  <= '0;
            ctrl4_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            ctrl3_reg  <= ctrl;
            ctrl4_reg  <= ctrl3_reg;
            strobe_reg <= ctrl4_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        grad_reg <= grad_next;
        last_reg <= ctrl4_reg.last;
    end

    assign gradient = signed'(grad_reg);
    assign last_out = last_reg;
    assign strobe   = strobe_reg;

endmodule

@@ rtl/sgs_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the sigmoid gradient scaler, bound to the top level.
// Depends on sgs_pkg and sigmoid_gradient_scaler.
module sgs_checker
    import sgs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic signed [15:0]       score,
    input logic                     last_in,
    input logic signed [GRAD_W-1:0] gradient,
    input logic                     last_out,
    input logic                     strobe
);

    // every taken item produces a result strobe
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##5 strobe)
        else $error("item taken without a result five cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy, 5))
        else $error("result without a matching item");

    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> last_out == $past(last_in, 5))
        else $error("last_out does not match its item");

    // table load happens once
    a_busy_once: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose after table load");

    a_low_score: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && $past(32'(score) < -SCORE_LIMIT, 5) |-> !gradient[GRAD_W-1])
        else $error("negative gradient for a score below the low limit");

endmodule

bind sigmoid_gradient_scaler sgs_checker u_sgs_checker (.*);

@@ tb/tb_sigmoid_gradient_scaler.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sigmoid_gradient_scaler: a gradient tracker class predicts
// every result, plain tasks drive the item and APB ports. Depends on sgs_pkg and the RTL.
module tb_sigmoid_gradient_scaler;
    import sgs_pkg::*;

    typedef struct {
        logic signed [GRAD_W-1:0] gradient;
        logic                     last;
    } grad_item_t;

    class grad_tracker;
        bit [16:0]  sig_table [DEF_TABLE_DEPTH];
        bit [15:0]  row_width;
        bit [15:0]  learning_rate;
        grad_item_t expected_grads [$];
        int         errors;
        int         checked;

        function new();
            for (int i = 0; i < DEF_TABLE_DEPTH; i++)
                sig_table[i] = table_value(i);
            row_width     = 16'(ROW_WIDTH_RST);
            learning_rate = 16'(LEARN_RATE_RST);
            errors        = 0;
            checked       = 0;
        endfunction

        // sigmoid at x = (2i - depth) * limit / depth, unsigned Q0.16, 64-bit wrapping math
        function bit [16:0] table_value(int i);
            bit [63:0] ek_q32 [8] = '{64'd4294967296, 64'd1580030169, 64'd581260615,
                                      64'd213833831, 64'd78665071, 64'd28939262,
                                      64'd10646160, 64'd3916504};
            longint    span;
            bit        neg;
            bit [63:0] mag;
            bit [63:0] t;
            bit [63:0] k;
            bit [63:0] f;
            bit [63:0] term;
            bit [63:0] ef;
            bit [63:0] e;
            bit [63:0] num;
            bit [63:0] den;
            bit [63:0] q;
            longint    sum;
            span = 2 * longint'(i) - longint'(DEF_TABLE_DEPTH);
            neg  = span < 0;
            mag  = 64'(neg ? -span : span);
            t    = (mag * 64'(CLAMP_LIMIT) * 64'h1_0000_0000) / 64'(DEF_TABLE_DEPTH);
            k    = t >> 32;
            f    = t & 64'hFFFF_FFFF;
            term = 64'h1_0000_0000;
            sum  = longint'(term);
            for (int n = 1; n <= TAYLOR_TERMS; n++)
            begin
                term = ((term * f) >> 32) / 64'(n);
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            ef = 64'(sum);
            if (k > 64'd7)
                k = 64'd7;
            e   = (ef * ek_q32[k[2:0]]) >> 32;
            num = neg ? e : 64'h1_0000_0000;
            den = 64'h1_0000_0000 + e;
            q   = ((num << 16) + (den >> 1)) / den;
            return q[16:0];
        endfunction

        function logic signed [GRAD_W-1:0] predict_gradient(logic signed [15:0] s,
                                                            logic [19:0] idx);
            int     sig;
            int     pos;
            int     ix;
            longint label;
            longint prod;
            longint g;
            if (s > SCORE_LIMIT)
                sig = Q16_ONE;
            else if (s < -SCORE_LIMIT)
                sig = 0;
            else
            begin
                pos = int'(s) + SCORE_LIMIT;
                ix  = pos * DEF_TABLE_DEPTH / (2 * SCORE_LIMIT);
                if (ix > DEF_TABLE_DEPTH - 1)
                    ix = DEF_TABLE_DEPTH - 1;
                sig = int'(sig_table[ix]);
            end
            label = (32'(idx) < 32'(row_width)) ? 0 : Q16_ONE;
            prod  = (label - longint'(sig)) * longint'(learning_rate);
            g     = (prod + 32768) >>> 16;
            if (g > 65535)
                g = 65535;
            if (g < -65536)
                g = -65536;
            return GRAD_W'(g);
        endfunction

        function void note_item(logic signed [15:0] s, logic [19:0] idx, logic last);
            grad_item_t want;
            want.gradient = predict_gradient(s, idx);
            want.last     = last;
            expected_grads.push_back(want);
        endfunction

        function void check_result(logic signed [GRAD_W-1:0] g, logic last);
            grad_item_t want;
            if (expected_grads.size() == 0)
            begin
                $error("result with nothing expected: gradient %0d last_out %0b", g, last);
                errors++;
                return;
            end
            want = expected_grads.pop_front();
            checked++;
            if (g !== want.gradient)
            begin
                $error("gradient: expected %0d, got %0d", want.gradient, g);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_out: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_grads.size();
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 100;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     psel          = 1'b0;
    logic                     penable       = 1'b0;
    logic                     pwrite        = 1'b0;
    logic [2:0]               paddr         = '0;
    logic [31:0]              pwdata        = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     start         = 1'b0;
    logic                     busy;
    logic signed [15:0]       score         = '0;
    logic [19:0]              element_index = '0;
    logic                     last_in       = 1'b0;
    logic signed [GRAD_W-1:0] gradient;
    logic                     last_out;
    logic                     strobe;

    grad_tracker tracker = new();
    int          items_in   = 0;
    int          quiet      = 0;
    int          cfg_writes = 0;

    sigmoid_gradient_scaler uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .score         (score),
        .element_index (element_index),
        .last_in       (last_in),
        .gradient      (gradient),
        .last_out      (last_out),
        .strobe        (strobe)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (start && busy === 1'b0)
        begin
            tracker.note_item(score, element_index, last_in);
            items_in++;
        end
        if (strobe === 1'b1)
            tracker.check_result(gradient, last_out);
        if ((start && busy === 1'b0) || strobe === 1'b1 || !rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("sigmoid_gradient_scaler: mismatch");
            $finish;
        end
    end

    task automatic send_item(logic signed [15:0] s, logic [19:0] idx, logic last,
                             int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        score         <= s;
        element_index <= idx;
        last_in       <= last;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r == REG_ROW_WIDTH)
            tracker.row_width = value;
        else
            tracker.learning_rate = value;
        cfg_writes++;
    endtask

    task automatic random_item(int idle_pct);
        logic signed [15:0] s;
        logic [19:0]        idx;
        int                 pick;
        pick = $urandom_range(9);
        if (pick < 5)
            s = 16'($urandom);
        else if (pick < 8)
            s = 16'($urandom_range(2 * SCORE_LIMIT) - SCORE_LIMIT);
        else if (pick == 8)
            s = 16'(($urandom_range(1) ? SCORE_LIMIT : -SCORE_LIMIT) + $urandom_range(6) - 3);
        else
            s = 16'($urandom_range(DEF_TABLE_DEPTH) * 48 + $urandom_range(2) - 1
                    - SCORE_LIMIT);
        if ($urandom_range(1))
            idx = 20'($urandom);
        else
            idx = 20'($urandom_range(2 * int'(tracker.row_width) + 1));
        send_item(s, idx, 1'($urandom), idle_pct);
    endtask

    initial
    begin
        logic signed [15:0] corner_scores [] = '{-16'sd32768, 16'sd32767, 16'sd24576,
                                                 -16'sd24576, 16'sd24577, -16'sd24577,
                                                 16'sd24575, -16'sd24575, 16'sd0, 16'sd1,
                                                 -16'sd1, 16'sd47, 16'sd48, -16'sd48,
                                                 16'sd2048, -16'sd2048};
        logic [15:0]        rw_list [PHASES] = '{16'd1, 16'd0, 16'd65535, 16'd65535,
                                                 16'd1, 16'd0, 16'd0, 16'd0};
        logic [15:0]        lr_list [PHASES] = '{16'd1638, 16'd65535, 16'd0, 16'd65535,
                                                 16'd1, 16'd32768, 16'd0, 16'd0};
        int                 idle_list [4] = '{0, 77, 31, 0};
        logic [19:0]        idx;
        rw_list[6] = 16'($urandom_range(1, 300));
        lr_list[6] = 16'($urandom);
        rw_list[7] = 16'($urandom);
        lr_list[7] = 16'($urandom);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, then explicit writes of the same values
        foreach (corner_scores[i])
        begin
            idx = (i % 3 == 0) ? 20'd0 : (i % 3 == 1) ? 20'd1 : 20'hFFFFF;
            send_item(corner_scores[i], idx, 1'(i % 2), 0);
        end
        wait_drained();
        write_reg(REG_ROW_WIDTH, rw_list[0]);
        write_reg(REG_LEARNING_RATE, lr_list[0]);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_drained();
                write_reg(REG_ROW_WIDTH, rw_list[p]);
                write_reg(REG_LEARNING_RATE, lr_list[p]);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 1 && n == PHASE_ITEMS / 2)
                    wait_drained();
                random_item(idle_list[p % 4]);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        $display("covered %0d items, %0d results checked, %0d register writes", items_in,
                 tracker.checked, cfg_writes);
        $display("clamped and table scores, label edges, row width zero and max, alpha extremes");
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("sigmoid_gradient_scaler: match");
        else
            $display("sigmoid_gradient_scaler: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/sgs_pkg.sv
rtl/sgs_ram.sv
rtl/sgs_rom.sv
rtl/sgs_front.sv
rtl/sgs_back.sv
rtl/sigmoid_gradient_scaler.sv
rtl/sgs_checker.sv
tb/tb_sigmoid_gradient_scaler.sv
